// ===== rtl/assert_macros.svh =====
// Assertion helpers, all sampled on the rising clock and off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define AST_HOLDS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed: invariant");

`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle rule");

`endif

// ===== rtl/fbat_pkg.sv =====
`timescale 1ns / 1ps
package fbat_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int CAP_W       = 7;
  localparam int CMP_W       = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int ADDR_W      = 32;
  localparam int COL_W       = 16;
  localparam int TOT_W       = 32;
  localparam int KEY_W       = 2 * ADDR_W + COL_W;
  localparam int WORD_W      = KEY_W + TOT_W;
  localparam int STAT_W      = 3;

  localparam logic ACT_ADD   = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;

  localparam logic [STAT_W-1:0] ST_NEW     = 3'd0;
  localparam logic [STAT_W-1:0] ST_MERGED  = 3'd1;
  localparam logic [STAT_W-1:0] ST_DROPPED = 3'd2;
  localparam logic [STAT_W-1:0] ST_DRAINED = 3'd3;
  localparam logic [STAT_W-1:0] ST_EMPTY   = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_TAIL,
    S_DECIDE,
    S_OUT
  } state_t;

endpackage

// ===== rtl/flow_byte_aggregation_table_core.sv =====
`timescale 1ns / 1ps
// Flow byte aggregation table.
// Input channel (in_valid/in_ready): one add or drain item per transfer.
// Result channel (out_valid/out_ready): exactly one result per item.
// Config: cfg_wr_en writes cfg_wr_data into the capacity register at once.
// An add at or above capacity is dropped straight away: the
// sequencer goes directly to its output state to load its result. Every
// other item walks the whole key/total memory, one entry per cycle
// through its single read port and one shared 80-bit key comparator,
// then decides and writes back.
// in_ready is high only while the sequencer is idle; a finished result
// sits in the output register while the next item is taken in. If the
// receiver stalls, the sequencer holds its result until that register frees.
// Reset clears the valid bits, live count and control state and sets
// capacity to 64; memory contents stay undefined and are never used for
// an entry that is not valid.
`include "assert_macros.svh"
module flow_byte_aggregation_table_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_action,
  input  logic [fbat_pkg::ADDR_W-1:0] in_src_addr,
  input  logic [fbat_pkg::ADDR_W-1:0] in_dst_addr,
  input  logic [fbat_pkg::COL_W-1:0]  in_colour,
  input  logic [fbat_pkg::TOT_W-1:0]  in_byte_size,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [fbat_pkg::STAT_W-1:0] out_status,
  output logic [fbat_pkg::ADDR_W-1:0] out_src,
  output logic [fbat_pkg::ADDR_W-1:0] out_dst,
  output logic [fbat_pkg::COL_W-1:0]  out_colour,
  output logic [fbat_pkg::TOT_W-1:0]  out_total,
  input  logic                        cfg_wr_en,
  input  logic [fbat_pkg::CAP_W-1:0]  cfg_wr_data
);
  import fbat_pkg::*;

  state_t state_r, state_nxt;

  logic [WORD_W-1:0]      mem [TABLE_DEPTH];
  logic [WORD_W-1:0]      rd_data_r;
  logic [TABLE_DEPTH-1:0] valid_r;
  logic [CNT_W-1:0]       live_count_r;
  logic [CAP_W-1:0]       capacity_r;

  logic [IDX_W-1:0]  idx_r;
  logic [IDX_W-1:0]  rd_idx_r;
  logic              cmp_v_r;
  logic              act_r;
  logic [KEY_W-1:0]  key_r;
  logic [TOT_W-1:0]  size_r;

  logic              sel_v_r;
  logic [IDX_W-1:0]  sel_idx_r;
  logic [KEY_W-1:0]  sel_key_r;
  logic [TOT_W-1:0]  sel_total_r;
  logic              free_v_r;
  logic [IDX_W-1:0]  free_idx_r;

  logic [STAT_W-1:0] res_status_r;
  logic [KEY_W-1:0]  res_key_r;
  logic [TOT_W-1:0]  res_total_r;

  logic              out_valid_r;
  logic [STAT_W-1:0] out_status_r;
  logic [KEY_W-1:0]  out_key_r;
  logic [TOT_W-1:0]  out_total_r;

  logic              accept;
  logic              at_cap;
  logic              scan_last;
  logic              rd_en;
  logic              out_load;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic [KEY_W-1:0]  ref_key;
  logic [KEY_W-1:0]  mem_key;
  logic              key_eq;
  logic              key_lt;
  logic              vbit;
  logic [TOT_W:0]    sum;
  logic [TOT_W-1:0]  sat_total;

  assign accept    = in_valid && in_ready;
  assign at_cap    = CMP_W'(live_count_r) >= CMP_W'(capacity_r);
  assign scan_last = idx_r == IDX_W'(TABLE_DEPTH - 1);

  // shared comparator
  assign mem_key = rd_data_r[WORD_W-1:TOT_W];
  assign ref_key = (act_r == ACT_DRAIN) ? sel_key_r : key_r;
  assign key_eq  = mem_key == ref_key;
  assign key_lt  = mem_key < ref_key;
  assign vbit    = valid_r[rd_idx_r];

  assign sum       = {1'b0, sel_total_r} + {1'b0, size_r};
  assign sat_total = sum[TOT_W] ? {TOT_W{1'b1}} : sum[TOT_W-1:0];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_action == ACT_ADD && at_cap) state_nxt = S_OUT;
          else state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_last) state_nxt = S_TAIL;
      end
      S_TAIL:   state_nxt = S_DECIDE;
      S_DECIDE: state_nxt = S_OUT;
      S_OUT: begin
        if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    out_load = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = free_idx_r;
    wr_data  = {key_r, size_r};
    case (state_r)
      S_IDLE: in_ready = 1'b1;
      S_SCAN: rd_en = 1'b1;
      S_DECIDE: begin
        if (act_r == ACT_ADD) begin
          if (sel_v_r) begin
            wr_en   = 1'b1;
            wr_addr = sel_idx_r;
            wr_data = {key_r, sat_total};
          end else if (free_v_r) begin
            wr_en = 1'b1;
          end
        end
      end
      S_OUT:   out_load = !out_valid_r || out_ready;
      default: in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      valid_r      <= '0;
      live_count_r <= '0;
      capacity_r   <= CAP_W'(64);
      cmp_v_r      <= 1'b0;
      out_valid_r  <= 1'b0;
      idx_r        <= '0;
    end else begin
      state_r <= state_nxt;
      cmp_v_r <= rd_en;
      if (cfg_wr_en) capacity_r <= cfg_wr_data;
      if (rd_en) idx_r <= idx_r + IDX_W'(1);
      else idx_r <= '0;
      if (state_r == S_DECIDE) begin
        if (act_r == ACT_ADD) begin
          if (!sel_v_r && free_v_r) begin
            valid_r[free_idx_r] <= 1'b1;
            live_count_r        <= live_count_r + CNT_W'(1);
          end
        end else if (sel_v_r) begin
          valid_r[sel_idx_r] <= 1'b0;
          live_count_r       <= live_count_r - CNT_W'(1);
        end
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= idx_r;
    if (accept) begin
      act_r        <= in_action;
      key_r        <= {in_src_addr, in_dst_addr, in_colour};
      size_r       <= in_byte_size;
      sel_v_r      <= 1'b0;
      free_v_r     <= 1'b0;
      res_status_r <= ST_DROPPED;
      res_key_r    <= '0;
      res_total_r  <= '0;
    end
    if (cmp_v_r) begin
      if (act_r == ACT_ADD) begin
        if (vbit && !sel_v_r && key_eq) begin
          sel_v_r     <= 1'b1;
          sel_idx_r   <= rd_idx_r;
          sel_total_r <= rd_data_r[TOT_W-1:0];
        end
        if (!vbit && !free_v_r) begin
          free_v_r   <= 1'b1;
          free_idx_r <= rd_idx_r;
        end
      end else if (vbit && (!sel_v_r || key_lt)) begin
        sel_v_r     <= 1'b1;
        sel_idx_r   <= rd_idx_r;
        sel_key_r   <= mem_key;
        sel_total_r <= rd_data_r[TOT_W-1:0];
      end
    end
    if (state_r == S_DECIDE) begin
      if (act_r == ACT_ADD) begin
        res_key_r <= '0;
        if (sel_v_r) begin
          res_status_r <= ST_MERGED;
          res_total_r  <= sat_total;
        end else if (free_v_r) begin
          res_status_r <= ST_NEW;
          res_total_r  <= '0;
        end else begin
          res_status_r <= ST_DROPPED;
          res_total_r  <= '0;
        end
      end else if (sel_v_r) begin
        res_status_r <= ST_DRAINED;
        res_key_r    <= sel_key_r;
        res_total_r  <= sel_total_r;
      end else begin
        res_status_r <= ST_EMPTY;
        res_key_r    <= '0;
        res_total_r  <= '0;
      end
    end
    if (out_load) begin
      out_status_r <= res_status_r;
      out_key_r    <= res_key_r;
      out_total_r  <= res_total_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_src    = out_key_r[KEY_W-1 -: ADDR_W];
  assign out_dst    = out_key_r[COL_W +: ADDR_W];
  assign out_colour = out_key_r[COL_W-1:0];
  assign out_total  = out_total_r;

  `AST_HOLDS(a_count_matches_valid, clk, rst_n,
    $countones(valid_r) == 32'(live_count_r))
  `AST_HOLDS(a_count_in_range, clk, rst_n, 32'(live_count_r) <= TABLE_DEPTH)
  `AST_NEXT(a_busy_after_accept, clk, rst_n, accept, !in_ready)

endmodule
